/* rtl/assert_macros.svh */
// assert_macros.svh
// Concurrent assertion wrappers shared by the RTL; defining ASSERT_OFF compiles them out.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/wsc_pkg.sv */
// wsc_pkg.sv
// Types, constants and the microcode ROM of the wildcard subsequence counter.
// No dependencies.
package wsc_pkg;

	localparam logic [29:0] PRIME       = 30'd1000000007;
	localparam logic [4:0]  WILDCARD    = 5'd26;
	localparam logic [4:0]  NUM_LETTERS = 5'd26;
	localparam int          CNT_W       = 30;
	localparam int          PROD_W      = 35;
	// quotient estimate: floor(top6 * 549 / 1024) never exceeds floor(x / PRIME)
	// and trails it by at most one
	localparam int          QE_MUL      = 549;
	localparam int          QE_SHIFT    = 10;
	localparam int          TOP_SHIFT   = 29;

	typedef logic [1:0] opcode_t;
	localparam opcode_t OP_CLEAR = 2'd0;
	localparam opcode_t OP_LOAD  = 2'd1;
	localparam opcode_t OP_TEXT  = 2'd2;
	localparam opcode_t OP_NOP   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_FULL   = 2'd1;
	localparam status_t ST_BADSYM = 2'd2;

	typedef enum logic [3:0] {
		A_NONE,
		A_INIT,
		A_TAKE,
		A_CLEAR,
		A_LOAD,
		A_BADSYM,
		A_FULL,
		A_TSTART,
		A_ISSUE,
		A_RESP
	} act_t;

	typedef enum logic [3:0] {
		J_NEXT,
		J_ALWAYS,
		J_DISPATCH,
		J_BADSYM,
		J_FULL,
		J_NOTEXT,
		J_MORE,
		J_BUSY,
		J_OUTBUSY
	} jmp_t;

	typedef logic [3:0] step_t;
	localparam step_t S_INIT   = 4'd0;
	localparam step_t S_FETCH  = 4'd1;
	localparam step_t S_CLR    = 4'd2;
	localparam step_t S_LD0    = 4'd3;
	localparam step_t S_LD1    = 4'd4;
	localparam step_t S_LD2    = 4'd5;
	localparam step_t S_LDBAD  = 4'd6;
	localparam step_t S_LDFULL = 4'd7;
	localparam step_t S_TX0    = 4'd8;
	localparam step_t S_TX1    = 4'd9;
	localparam step_t S_TX2    = 4'd10;
	localparam step_t S_RESP0  = 4'd11;
	localparam step_t S_RESP1  = 4'd12;

	typedef struct packed {
		act_t  act;
		jmp_t  jmp;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic    accept;
		opcode_t opcode;
		logic    bad_sym;
		logic    full;
		logic    no_text;
		logic    more;
		logic    busy;
		logic    out_busy;
	} dp_flags_t;

	// a jump not taken falls through to the next step
	function automatic uword_t ucode(input step_t pc);
		uword_t w;
		case (pc)
			S_INIT:   w = '{act: A_INIT,   jmp: J_ALWAYS,   target: S_FETCH};
			S_FETCH:  w = '{act: A_TAKE,   jmp: J_DISPATCH, target: S_FETCH};
			S_CLR:    w = '{act: A_CLEAR,  jmp: J_ALWAYS,   target: S_RESP0};
			S_LD0:    w = '{act: A_NONE,   jmp: J_BADSYM,   target: S_LDBAD};
			S_LD1:    w = '{act: A_NONE,   jmp: J_FULL,     target: S_LDFULL};
			S_LD2:    w = '{act: A_LOAD,   jmp: J_ALWAYS,   target: S_RESP0};
			S_LDBAD:  w = '{act: A_BADSYM, jmp: J_ALWAYS,   target: S_RESP0};
			S_LDFULL: w = '{act: A_FULL,   jmp: J_ALWAYS,   target: S_RESP0};
			S_TX0:    w = '{act: A_TSTART, jmp: J_NOTEXT,   target: S_RESP0};
			S_TX1:    w = '{act: A_ISSUE,  jmp: J_MORE,     target: S_TX1};
			S_TX2:    w = '{act: A_NONE,   jmp: J_BUSY,     target: S_TX2};
			S_RESP0:  w = '{act: A_NONE,   jmp: J_OUTBUSY,  target: S_RESP0};
			S_RESP1:  w = '{act: A_RESP,   jmp: J_ALWAYS,   target: S_FETCH};
			default:  w = '{act: A_NONE,   jmp: J_ALWAYS,   target: S_FETCH};
		endcase
		return w;
	endfunction

endpackage

/* rtl/wsc_in_if.sv */
// wsc_in_if.sv
// Input channel of the counter: opcode and symbol with valid/ready.
// No dependencies.
interface wsc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [4:0] symbol;

	modport source(output valid, output opcode, output symbol, input ready);
	modport sink(input valid, input opcode, input symbol, output ready);
endinterface

/* rtl/wsc_out_if.sv */
// wsc_out_if.sv
// Result channel of the counter: count and status with valid/ready.
// No dependencies.
interface wsc_out_if;
	logic        valid;
	logic        ready;
	logic [29:0] count;
	logic [1:0]  status;

	modport source(output valid, output count, output status, input ready);
	modport sink(input valid, input count, input status, output ready);
endinterface

/* rtl/wsc_seq.sv */
// wsc_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on wsc_pkg.
module wsc_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  wsc_pkg::dp_flags_t  flags,
	output wsc_pkg::act_t       act
);

	wsc_pkg::step_t  pc_q;
	wsc_pkg::step_t  pc_next;
	wsc_pkg::step_t  dest;
	wsc_pkg::uword_t uw;
	logic            take_jump;

	assign uw  = wsc_pkg::ucode(pc_q);
	assign act = uw.act;

	always_comb begin
		take_jump = 1'b0;
		dest      = uw.target;
		case (uw.jmp)
			wsc_pkg::J_NEXT:    take_jump = 1'b0;
			wsc_pkg::J_ALWAYS:  take_jump = 1'b1;
			wsc_pkg::J_DISPATCH: begin
				take_jump = 1'b1;
				if (flags.accept) begin
					case (flags.opcode)
						wsc_pkg::OP_CLEAR: dest = wsc_pkg::S_CLR;
						wsc_pkg::OP_LOAD:  dest = wsc_pkg::S_LD0;
						wsc_pkg::OP_TEXT:  dest = wsc_pkg::S_TX0;
						wsc_pkg::OP_NOP:   dest = wsc_pkg::S_RESP0;
						default:           dest = wsc_pkg::S_RESP0;
					endcase
				end else begin
					dest = pc_q;
				end
			end
			wsc_pkg::J_BADSYM:  take_jump = flags.bad_sym;
			wsc_pkg::J_FULL:    take_jump = flags.full;
			wsc_pkg::J_NOTEXT:  take_jump = flags.no_text;
			wsc_pkg::J_MORE:    take_jump = flags.more;
			wsc_pkg::J_BUSY:    take_jump = flags.busy;
			wsc_pkg::J_OUTBUSY: take_jump = flags.out_busy;
			default:            take_jump = 1'b0;
		endcase
		pc_next = take_jump ? dest : pc_q + 4'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= wsc_pkg::S_INIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

/* rtl/wsc_dp.sv */
// wsc_dp.sv
// Datapath: pattern and count memories, pattern bookkeeping, the modular
// multiply-add pipeline that rewrites the count row, and the result register.
// Depends on wsc_pkg, wsc_in_if, wsc_out_if.
module wsc_dp #(
	parameter int MAX_PATTERN = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wsc_pkg::act_t      act,
	output wsc_pkg::dp_flags_t flags,
	wsc_in_if.sink             item,
	wsc_out_if.source          result
);

	localparam int RA_W = $clog2(MAX_PATTERN + 1);
	localparam int PA_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int PW   = wsc_pkg::PROD_W;
	localparam int CW   = wsc_pkg::CNT_W;
	localparam logic [RA_W-1:0] LEN_FULL = RA_W'(MAX_PATTERN);

	// memories
	logic [CW-1:0] row_mem [MAX_PATTERN+1];
	logic [4:0]    pat_mem [MAX_PATTERN];

	// bookkeeping
	logic [RA_W-1:0]      len_q;
	logic [25:0]          seen_q;
	logic [4:0]           distinct_q;
	logic [CW-1:0]        count_q;
	logic [RA_W-1:0]      j_q;
	logic [4:0]           sym_q;
	logic [4:0]           factor_q;
	logic                 wild_q;
	wsc_pkg::status_t     status_q;
	logic                 res_valid_q;
	logic [CW-1:0]        res_count_q;
	wsc_pkg::status_t     res_status_q;

	// pipeline
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [RA_W-1:0]      j_s1, j_s2, j_s3, j_s4, j_s5;
	logic                 top_s1, top_s2, top_s3, top_s4, top_s5;
	logic [CW-1:0]        row_rd_s1;
	logic [4:0]           pat_rd_s1;
	logic [CW-1:0]        val_s2;
	logic                 m_s2;
	logic [PW-1:0]        prod_s3;
	logic [CW-1:0]        add_s3, add_s4, add_s5;
	logic [CW:0]          rem_s4;
	logic [CW-1:0]        red_s5;

	// combinational
	logic                 issue;
	logic [RA_W-1:0]      j_dec;
	logic [PA_W-1:0]      pat_raddr;
	logic                 match_s1;
	logic [CW-1:0]        addend_s2;
	logic [PW-1:0]        prod;
	logic [5:0]           top6;
	logic [15:0]          qe_full;
	logic [5:0]           qe;
	logic [PW-1:0]        rem_full;
	logic [CW-1:0]        red;
	logic [CW:0]          sum;
	logic [CW:0]          sum_red;
	logic [CW-1:0]        res;
	logic                 row_we;
	logic [RA_W-1:0]      row_waddr;
	logic [CW-1:0]        row_wdata;
	logic [RA_W-1:0]      len_inc;

	assign issue     = (act == wsc_pkg::A_ISSUE);
	assign j_dec     = j_q - RA_W'(1);
	assign pat_raddr = j_dec[PA_W-1:0];
	assign len_inc   = len_q + RA_W'(1);

	// entry j takes count_row[j-1] when its pattern letter matches, or always for a wildcard
	assign match_s1  = (j_s1 != '0) && (wild_q || (pat_rd_s1 == sym_q));
	// s1 now holds the read of the next lower entry, i.e. the old count_row[j-1]
	assign addend_s2 = m_s2 ? row_rd_s1 : '0;
	assign prod      = PW'(factor_q) * PW'(val_s2);

	assign top6      = prod_s3[PW-1:wsc_pkg::TOP_SHIFT];
	assign qe_full   = 16'(top6) * 16'(wsc_pkg::QE_MUL);
	assign qe        = qe_full[wsc_pkg::QE_SHIFT +: 6];
	assign rem_full  = prod_s3 - PW'(qe) * PW'(wsc_pkg::PRIME);

	assign red       = (rem_s4 >= {1'b0, wsc_pkg::PRIME}) ?
	                   CW'(rem_s4 - {1'b0, wsc_pkg::PRIME}) : rem_s4[CW-1:0];

	assign sum       = {1'b0, red_s5} + {1'b0, add_s5};
	assign sum_red   = (sum >= {1'b0, wsc_pkg::PRIME}) ? sum - {1'b0, wsc_pkg::PRIME} : sum;
	assign res       = sum_red[CW-1:0];

	always_comb begin
		row_we    = 1'b0;
		row_waddr = '0;
		row_wdata = '0;
		if (v_s5) begin
			row_we    = 1'b1;
			row_waddr = j_s5;
			row_wdata = res;
		end else begin
			case (act)
				wsc_pkg::A_INIT, wsc_pkg::A_CLEAR: begin
					row_we    = 1'b1;
					row_wdata = CW'(1);
				end
				wsc_pkg::A_LOAD: begin
					// the new top entry starts at zero
					row_we    = 1'b1;
					row_waddr = len_inc;
				end
				default: row_we = 1'b0;
			endcase
		end
	end

	// memories: registered reads every cycle
	always_ff @(posedge clk) begin
		row_rd_s1 <= row_mem[j_q];
		pat_rd_s1 <= pat_mem[pat_raddr];
		if (row_we) begin
			row_mem[row_waddr] <= row_wdata;
		end
		if (act == wsc_pkg::A_LOAD) begin
			pat_mem[len_q[PA_W-1:0]] <= sym_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			seen_q      <= '0;
			distinct_q  <= '0;
			count_q     <= CW'(1);
			j_q         <= '0;
			res_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;

			if (v_s5 && top_s5) begin
				count_q <= res;
			end

			case (act)
				wsc_pkg::A_INIT: count_q <= CW'(1);
				wsc_pkg::A_CLEAR: begin
					len_q      <= '0;
					seen_q     <= '0;
					distinct_q <= '0;
					count_q    <= CW'(1);
				end
				wsc_pkg::A_LOAD: begin
					len_q   <= len_inc;
					count_q <= '0;
					if (!seen_q[sym_q]) begin
						seen_q[sym_q] <= 1'b1;
						distinct_q    <= distinct_q + 5'd1;
					end
				end
				wsc_pkg::A_TSTART: j_q <= len_q;
				wsc_pkg::A_ISSUE:  j_q <= j_dec;
				default: ;
			endcase

			if (act == wsc_pkg::A_RESP) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (flags.accept) begin
			sym_q    <= item.symbol;
			status_q <= wsc_pkg::ST_OK;
		end
		case (act)
			wsc_pkg::A_BADSYM: status_q <= wsc_pkg::ST_BADSYM;
			wsc_pkg::A_FULL:   status_q <= wsc_pkg::ST_FULL;
			wsc_pkg::A_TSTART: begin
				wild_q   <= (sym_q == wsc_pkg::WILDCARD);
				factor_q <= (sym_q == wsc_pkg::WILDCARD) ? distinct_q : 5'd1;
			end
			wsc_pkg::A_RESP: begin
				res_count_q  <= count_q;
				res_status_q <= status_q;
			end
			default: ;
		endcase

		j_s1    <= j_q;
		top_s1  <= (j_q == len_q);

		val_s2  <= row_rd_s1;
		m_s2    <= match_s1;
		j_s2    <= j_s1;
		top_s2  <= top_s1;

		prod_s3 <= prod;
		add_s3  <= addend_s2;
		j_s3    <= j_s2;
		top_s3  <= top_s2;

		rem_s4  <= rem_full[CW:0];
		add_s4  <= add_s3;
		j_s4    <= j_s3;
		top_s4  <= top_s3;

		red_s5  <= red;
		add_s5  <= add_s4;
		j_s5    <= j_s4;
		top_s5  <= top_s4;
	end

	assign item.ready    = (act == wsc_pkg::A_TAKE);
	assign result.valid  = res_valid_q;
	assign result.count  = res_count_q;
	assign result.status = res_status_q;

	assign flags.accept   = item.valid && item.ready;
	assign flags.opcode   = item.opcode;
	assign flags.bad_sym  = (sym_q >= wsc_pkg::NUM_LETTERS);
	assign flags.full     = (len_q == LEN_FULL);
	assign flags.no_text  = (sym_q > wsc_pkg::WILDCARD);
	assign flags.more     = (j_q != '0);
	assign flags.busy     = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign flags.out_busy = res_valid_q && !result.ready;

endmodule

/* rtl/wildcard_subsequence_counter.sv */
// Wildcard subsequence counter. Every transaction on item returns exactly one
// transaction on result carrying the count of pattern occurrences modulo
// 1000000007 and a status. After reset an initial step sets entry 0 of the
// count row to one before the first item is taken. A clear passes the clear
// step, a pattern letter is checked for a bad symbol and a full pattern before it
// is stored, and opcode 3 goes straight to the response. For a text symbol the
// count row is read one entry per cycle from the highest entry down through the
// single read port of the count memory, and each entry passes a five-stage
// multiply, reduce and add pipeline that must drain before the result is issued.
// A finished result waits in an output register while the next item is accepted.
`include "assert_macros.svh"

module wildcard_subsequence_counter #(
	parameter int MAX_PATTERN = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	wsc_in_if.sink    item,
	wsc_out_if.source result
);

	wsc_pkg::act_t      act;
	wsc_pkg::dp_flags_t flags;

	wsc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.act    (act)
	);

	wsc_dp #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.act    (act),
		.flags  (flags),
		.item   (item),
		.result (result)
	);

	// no new transaction while the row update is still in flight
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, item.ready, !flags.busy, "item taken during row update")
	`ASSERT_IMPL(a_count_range, clk, arst_n, result.valid, result.count < wsc_pkg::PRIME, "count not reduced")
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, item.valid && item.ready, !item.ready, "second item taken back to back")

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// tb_top.sv - self-checking bench for the wildcard subsequence counter.
// Drives random item and result handshakes and predicts every count and status.
// Depends on wsc_pkg, wsc_in_if, wsc_out_if and wildcard_subsequence_counter.
module tb_top;
	import wsc_pkg::*;

	localparam int              PATTERN_CAP    = 256;
	localparam int              RANDOM_ITEMS   = 1000;
	localparam int              HOLD_AFTER     = 300;
	localparam int              HOLD_CYCLES    = 400;
	localparam int              TAIL_CYCLES    = 300;
	localparam int              WATCHDOG_LIMIT = 4000;
	localparam longint unsigned MODULUS        = longint'(PRIME);

	typedef struct {
		opcode_t    op;
		logic [4:0] sym;
	} symbol_item_t;

	typedef struct {
		logic [29:0] count;
		status_t     status;
	} count_result_t;

	logic clk;
	logic arst_n;

	wsc_in_if  item_ch();
	wsc_out_if result_ch();

	wildcard_subsequence_counter #(.MAX_PATTERN(PATTERN_CAP)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// counter state as predicted
	logic [29:0] occ_row [0:PATTERN_CAP];
	logic [4:0]  pat_letters [0:PATTERN_CAP-1];
	int          pat_len;
	logic [25:0] seen_mask;
	int          distinct_cnt;

	symbol_item_t  pending_items[$];
	count_result_t expected_counts[$];

	logic item_taken   = 1'b0;
	logic result_taken = 1'b0;
	logic send_burst   = 1'b0;
	logic recv_burst   = 1'b0;
	logic holdoff_done = 1'b0;
	int   gap_cnt      = 0;
	int   stall_cnt    = 0;
	int   hold_cnt     = 0;
	int   idle_cycles  = 0;
	int   items_in     = 0;
	int   results_seen = 0;
	int   fail_count   = 0;
	int   longest_pat  = 0;
	int   most_letters = 0;
	int   full_drops   = 0;

	function automatic logic [29:0] mod_add(input longint unsigned a, input longint unsigned b);
		longint unsigned s;
		s = a + b;
		if (s >= MODULUS)
			s = s - MODULUS;
		return s[29:0];
	endfunction

	function automatic void clear_counter();
		for (int j = 0; j <= PATTERN_CAP; j++)
			occ_row[j] = '0;
		occ_row[0]   = 30'd1;
		pat_len      = 0;
		seen_mask    = '0;
		distinct_cnt = 0;
	endfunction

	function automatic void count_occurrences(input opcode_t op, input logic [4:0] sym,
			output logic [29:0] cnt, output status_t st);
		longint unsigned prod;
		st = ST_OK;
		case (op)
			OP_CLEAR: begin
				clear_counter();
			end
			OP_LOAD: begin
				// bad-symbol check takes priority over the full check
				if (sym >= NUM_LETTERS) begin
					st = ST_BADSYM;
				end else if (pat_len >= PATTERN_CAP) begin
					st = ST_FULL;
					full_drops++;
				end else begin
					pat_letters[pat_len] = sym;
					pat_len++;
					if (!seen_mask[sym]) begin
						seen_mask[sym] = 1'b1;
						distinct_cnt++;
					end
				end
			end
			OP_TEXT: begin
				if (sym == WILDCARD) begin
					for (int j = pat_len; j >= 1; j--) begin
						prod = (longint'(distinct_cnt) * longint'(occ_row[j])) % MODULUS;
						occ_row[j] = mod_add(prod, longint'(occ_row[j-1]));
					end
					prod = (longint'(distinct_cnt) * longint'(occ_row[0])) % MODULUS;
					occ_row[0] = prod[29:0];
				end else if (sym < NUM_LETTERS) begin
					for (int j = pat_len; j >= 1; j--)
						if (pat_letters[j-1] == sym)
							occ_row[j] = mod_add(longint'(occ_row[j]), longint'(occ_row[j-1]));
				end
			end
			default: ;
		endcase
		cnt = occ_row[pat_len];
		if (pat_len > longest_pat)
			longest_pat = pat_len;
		if (distinct_cnt > most_letters)
			most_letters = distinct_cnt;
	endfunction

	task automatic add_item(input opcode_t op, input logic [4:0] sym);
		symbol_item_t it;
		it.op  = op;
		it.sym = sym;
		pending_items.push_back(it);
	endtask

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// accepted item transactions feed the predictor
	always @(posedge clk) begin : predict_items
		logic [29:0] c;
		status_t     s;
		item_taken <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			count_occurrences(item_ch.opcode, item_ch.symbol, c, s);
			expected_counts.push_back('{count: c, status: s});
			items_in++;
		end
	end

	always @(posedge clk) begin : check_results
		count_result_t exp_r;
		result_taken <= arst_n && result_ch.valid && result_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (expected_counts.size() == 0) begin
				$error("result with nothing pending: count %0d status %0d",
					result_ch.count, result_ch.status);
				fail_count++;
			end else begin
				exp_r = expected_counts.pop_front();
				if (result_ch.count !== exp_r.count) begin
					$error("count: expected %0d, actual %0d", exp_r.count, result_ch.count);
					fail_count++;
				end
				if (result_ch.status !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, result_ch.status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	always @(negedge clk) begin : drive_items
		logic         v;
		symbol_item_t cur;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else begin
			v = item_ch.valid;
			if (item_ch.valid && item_taken) begin
				v = 1'b0;
				gap_cnt = send_burst ? 0 : $urandom_range(0, 11);
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
			end
			if (!v) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
				end else if (pending_items.size() > 0) begin
					cur = pending_items.pop_front();
					item_ch.opcode <= cur.op;
					item_ch.symbol <= cur.sym;
					v = 1'b1;
				end
			end
			item_ch.valid <= v;
		end
	end

	always @(negedge clk) begin : accept_results
		logic rdy;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_taken) begin
				// one long hold-off so the block backs up onto its input
				if (!holdoff_done && results_seen >= HOLD_AFTER) begin
					hold_cnt     = HOLD_CYCLES;
					holdoff_done = 1'b1;
				end else begin
					stall_cnt = recv_burst ? 0 : $urandom_range(0, 11);
				end
				if ($urandom_range(0, 39) == 0)
					recv_burst = !recv_burst;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rdy = 1'b0;
			end else if (stall_cnt > 0) begin
				rdy = 1'b0;
				if (result_ch.valid)
					stall_cnt--;
			end else begin
				rdy = 1'b1;
			end
			result_ch.ready <= rdy;
		end
	end

	initial begin : stimulus
		logic [4:0] seq_pat [0:PATTERN_CAP-1];
		int         k;
		int         m;
		int         r;
		int         base;
		int         span;
		logic       filled;
		logic [4:0] s;

		item_ch.valid   = 1'b0;
		item_ch.opcode  = OP_NOP;
		item_ch.symbol  = '0;
		result_ch.ready = 1'b0;
		arst_n          = 1'b0;
		filled          = 1'b0;
		clear_counter();

		// directed: empty pattern, bad pattern symbols, extremes, late letter, nop
		add_item(OP_TEXT, 5'd0);
		add_item(OP_TEXT, WILDCARD);
		add_item(OP_CLEAR, 5'd0);
		add_item(OP_LOAD, WILDCARD);
		add_item(OP_LOAD, 5'd31);
		add_item(OP_LOAD, 5'd0);
		add_item(OP_LOAD, 5'd25);
		add_item(OP_LOAD, 5'd0);
		add_item(OP_TEXT, 5'd0);
		add_item(OP_TEXT, 5'd25);
		add_item(OP_TEXT, 5'd0);
		add_item(OP_TEXT, WILDCARD);
		add_item(OP_TEXT, 5'd31);
		add_item(OP_TEXT, 5'd27);
		add_item(OP_NOP, 5'd31);
		add_item(OP_LOAD, 5'd12);
		add_item(OP_TEXT, 5'd12);
		add_item(OP_TEXT, WILDCARD);
		add_item(OP_TEXT, WILDCARD);
		add_item(OP_NOP, 5'd0);
		add_item(OP_CLEAR, 5'd31);

		while (pending_items.size() < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (!filled && pending_items.size() >= 400) begin
				// fill the pattern to capacity, then overflow it
				filled = 1'b1;
				add_item(OP_CLEAR, 5'($urandom_range(0, 31)));
				for (int i = 0; i < PATTERN_CAP; i++)
					add_item(OP_LOAD, 5'($urandom_range(0, 25)));
				add_item(OP_LOAD, 5'($urandom_range(0, 25)));
				add_item(OP_LOAD, WILDCARD);
				add_item(OP_LOAD, 5'd25);
				for (int i = 0; i < 6; i++)
					add_item(OP_TEXT, ($urandom_range(0, 1) == 0) ? WILDCARD
						: 5'($urandom_range(0, 25)));
			end else if (r < 85) begin
				add_item(OP_CLEAR, 5'($urandom_range(0, 31)));
				k    = $urandom_range(1, 10);
				base = $urandom_range(0, 25);
				span = $urandom_range(1, 8);
				for (int i = 0; i < k; i++) begin
					seq_pat[i] = 5'((base + $urandom_range(0, span - 1)) % 26);
					add_item(OP_LOAD, seq_pat[i]);
					if ($urandom_range(0, 9) == 0)
						add_item(OP_LOAD, 5'($urandom_range(26, 31)));
				end
				m = $urandom_range(1, 20);
				for (int i = 0; i < m; i++) begin
					r = $urandom_range(0, 99);
					if (r < 3 && k < PATTERN_CAP) begin
						s = 5'($urandom_range(0, 25));
						seq_pat[k] = s;
						k++;
						add_item(OP_LOAD, s);
					end else if (r < 45) begin
						add_item(OP_TEXT, seq_pat[$urandom_range(0, k - 1)]);
					end else if (r < 70) begin
						add_item(OP_TEXT, WILDCARD);
					end else if (r < 88) begin
						add_item(OP_TEXT, 5'($urandom_range(0, 25)));
					end else if (r < 95) begin
						add_item(OP_TEXT, 5'($urandom_range(27, 31)));
					end else begin
						add_item(OP_NOP, 5'($urandom_range(0, 31)));
					end
				end
			end else begin
				m = $urandom_range(1, 5);
				for (int i = 0; i < m; i++)
					add_item(opcode_t'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || item_ch.valid || expected_counts.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_counts.size() != 0) begin
			$error("%0d results never arrived", expected_counts.size());
			fail_count++;
		end
		$display("Run: %0d items in, %0d results out, %0d mismatches.",
			items_in, results_seen, fail_count);
		$display("Longest pattern %0d, up to %0d distinct letters, %0d full-pattern drops.",
			longest_pat, most_letters, full_drops);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
